// ===== hdl/grid_local_peak_finder_assert.svh =====
// assertion helpers shared by the peak finder modules
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef GRID_LOCAL_PEAK_FINDER_ASSERT_SVH
`define GRID_LOCAL_PEAK_FINDER_ASSERT_SVH

// consequence must hold in the same cycle
`define GLPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the next cycle
`define GLPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/glpf_pkg.sv =====
`timescale 1ns / 1ps

package glpf_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int COORD_W    = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } t_opcode;

    // decision handed from the counter stage to the compare stage
    typedef struct packed {
        logic load;       // a decision enters the compare stage
        logic has_down;   // the arriving sample is the lower neighbor
        logic has_right;  // column to the right is inside the matrix
        logic odd;        // decided row lives in the lower line store
    } t_dec_ctl;

endpackage

// ===== hdl/glpf_line_store.sv =====
`timescale 1ns / 1ps

module glpf_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    // read-first: a read at the write address returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/glpf_ctrl.sv =====
`timescale 1ns / 1ps
`include "grid_local_peak_finder_assert.svh"

module glpf_ctrl #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_COLS     = 1024,
    parameter int SAMPLE_WIDTH = 16,
    parameter int RW           = 11,
    parameter int DRW          = 10,
    parameter int AW           = 10,
    parameter int CW           = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [glpf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_acc,
    input  logic                            i_opcode,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_value,
    output glpf_pkg::t_dec_ctl              o_dec,
    output logic [DRW-1:0]                  o_drow,
    output logic [AW-1:0]                   o_dcol,
    output logic signed [SAMPLE_WIDTH-1:0]  o_down,
    output logic                            o_we_upper,
    output logic                            o_we_lower,
    output logic [AW-1:0]                   o_waddr,
    output logic [SAMPLE_WIDTH-1:0]         o_wdata,
    output logic [AW-1:0]                   o_raddr_a,
    output logic [AW-1:0]                   o_raddr_b
);

    import glpf_pkg::*;

    logic [RW-1:0]  r_rows, n_rows;
    logic [CW-1:0]  r_cols, n_cols;
    logic [RW-1:0]  r_irow, n_irow;
    logic [AW-1:0]  r_icol, n_icol;
    logic [DRW-1:0] r_drow, n_drow;
    logic [AW-1:0]  r_dcol, n_dcol;

    logic is_sample;
    logic in_open;
    logic icol_last;
    logic dcol_last;
    logic drow_last;
    logic sample_ok;
    logic sample_dec;
    logic flush_ok;
    logic [RW-1:0] cfg_rows;
    logic [CW-1:0] cfg_cols;

    always_comb begin
        is_sample  = t_opcode'(i_opcode) == OP_SAMPLE;
        in_open    = r_irow < r_rows;
        icol_last  = (CW'(r_icol) + CW'(1)) == r_cols;
        dcol_last  = (CW'(r_dcol) + CW'(1)) == r_cols;
        drow_last  = (RW'(r_drow) + RW'(1)) == r_rows;
        sample_ok  = is_sample && in_open;
        sample_dec = sample_ok && (r_irow != '0);
        flush_ok   = !is_sample && !in_open;

        // zero counts act as one, large counts saturate
        if (i_cfg_data == '0) begin
            cfg_rows = RW'(1);
            cfg_cols = CW'(1);
        end else begin
            cfg_rows = (int'(i_cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(i_cfg_data);
            cfg_cols = (int'(i_cfg_data) > MAX_COLS) ? CW'(MAX_COLS) : CW'(i_cfg_data);
        end
    end

    always_comb begin
        o_dec.load      = i_acc && (sample_dec || flush_ok);
        o_dec.has_down  = is_sample;
        o_dec.has_right = (CW'(r_dcol) + CW'(1)) < r_cols;
        o_dec.odd       = r_drow[0];
        o_drow          = r_drow;
        o_dcol          = r_dcol;
        o_down          = i_sample_value;
        o_we_upper      = i_acc && sample_ok && !r_irow[0];
        o_we_lower      = i_acc && sample_ok && r_irow[0];
        o_waddr         = r_icol;
        o_wdata         = i_sample_value;
        o_raddr_a       = r_dcol;
        o_raddr_b       = r_dcol + AW'(1);
    end

    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        n_irow = r_irow;
        n_icol = r_icol;
        n_drow = r_drow;
        n_dcol = r_dcol;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_ROW_COUNT: n_rows = cfg_rows;
                REG_COL_COUNT: n_cols = cfg_cols;
            endcase
            n_irow = '0;
            n_icol = '0;
            n_drow = '0;
            n_dcol = '0;
        end else if (i_acc) begin
            if (sample_ok) begin
                if (icol_last) begin
                    n_icol = '0;
                    n_irow = r_irow + RW'(1);
                end else begin
                    n_icol = r_icol + AW'(1);
                end
            end
            if (sample_dec || (flush_ok && !(dcol_last && drow_last))) begin
                if (dcol_last) begin
                    n_dcol = '0;
                    n_drow = r_drow + DRW'(1);
                end else begin
                    n_dcol = r_dcol + AW'(1);
                end
            end else if (flush_ok) begin
                // last sample decided: ready for the next matrix
                n_irow = '0;
                n_icol = '0;
                n_drow = '0;
                n_dcol = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RW'(1);
            r_cols <= CW'(1);
            r_irow <= '0;
            r_icol <= '0;
            r_drow <= '0;
            r_dcol <= '0;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            r_irow <= n_irow;
            r_icol <= n_icol;
            r_drow <= n_drow;
            r_dcol <= n_dcol;
        end
    end

    // while samples flow the decided position trails the input by one row
    `GLPF_ASSERT_NOW(a_decide_trails_input, (r_irow != '0 && r_irow < r_rows),
        (r_dcol == r_icol && (RW'(r_drow) + RW'(1)) == r_irow),
        "decide position does not trail input by one row")

endmodule

// ===== hdl/glpf_decide.sv =====
`timescale 1ns / 1ps
`include "grid_local_peak_finder_assert.svh"

module glpf_decide #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DRW          = 10,
    parameter int AW           = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  glpf_pkg::t_dec_ctl              i_dec,
    input  logic [DRW-1:0]                  i_drow,
    input  logic [AW-1:0]                   i_dcol,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_down,
    input  logic [SAMPLE_WIDTH-1:0]         i_upper_a,
    input  logic [SAMPLE_WIDTH-1:0]         i_upper_b,
    input  logic [SAMPLE_WIDTH-1:0]         i_lower_a,
    input  logic [SAMPLE_WIDTH-1:0]         i_lower_b,
    input  logic                            i_stall,
    output logic                            o_ready,
    output logic                            o_valid,
    output logic [glpf_pkg::COORD_W-1:0]    o_peak_row,
    output logic [glpf_pkg::COORD_W-1:0]    o_peak_col
);

    import glpf_pkg::*;

    logic                           r_s1_valid;
    glpf_pkg::t_dec_ctl             r_s1_ctl;
    logic [DRW-1:0]                 r_s1_row;
    logic [AW-1:0]                  r_s1_col;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_down;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic                           r_out_valid;
    logic [COORD_W-1:0]             r_out_row;
    logic [COORD_W-1:0]             r_out_col;

    logic signed [SAMPLE_WIDTH-1:0] mid;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic signed [SAMPLE_WIDTH-1:0] above;
    logic s1_found;
    logic out_free;
    logic s1_move;

    always_comb begin
        mid   = r_s1_ctl.odd ? i_lower_a : i_upper_a;
        right = r_s1_ctl.odd ? i_lower_b : i_upper_b;
        above = r_s1_ctl.odd ? i_upper_a : i_lower_a;
        s1_found = !((r_s1_row != '0) && (mid < above))
                && !((r_s1_col != '0) && (mid < r_left))
                && !(r_s1_ctl.has_right && (mid < right))
                && !(r_s1_ctl.has_down && (mid < r_s1_down));
        out_free = !r_out_valid || !i_stall;
        s1_move  = r_s1_valid && (!s1_found || out_free);
        o_ready  = !r_s1_valid || s1_move;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_dec.load;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid && s1_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_dec.load) begin
            r_s1_ctl  <= i_dec;
            r_s1_row  <= i_drow;
            r_s1_col  <= i_dcol;
            r_s1_down <= i_down;
        end
        // this sample is the left neighbor of the next decision in the row
        if (s1_move) begin
            r_left <= mid;
        end
        if (out_free) begin
            r_out_row <= COORD_W'(r_s1_row);
            r_out_col <= COORD_W'(r_s1_col);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_peak_row = r_out_row;
    assign o_peak_col = r_out_col;

    `GLPF_ASSERT_NEXT(a_blocked_decision_kept,
        (r_s1_valid && s1_found && r_out_valid && i_stall), (r_s1_valid),
        "blocked decision was dropped")
    `GLPF_ASSERT_NEXT(a_found_reaches_output, (s1_move && s1_found), (r_out_valid),
        "detected peak did not reach the output register")
    `GLPF_ASSERT_NOW(a_stall_only_when_full, (!o_ready),
        (r_s1_valid && s1_found && r_out_valid && i_stall),
        "input stalled without a blocked peak")

endmodule

// ===== hdl/grid_local_peak_finder.sv =====
`timescale 1ns / 1ps

// Four-neighbor local maximum finder over a matrix streamed in row-major order.
// Each transfer is a sample (opcode 0) or a flush tick (opcode 1); after the
// row_count*col_count samples, col_count flush ticks finish the last row. A
// sample at (r,c) decides position (r-1,c), so peaks come out in row-major
// order. One item is taken every clock unless the input is held off: the
// counter stage writes the sample into one of two line stores and reads the
// decided row at c and c+1 plus the row above at c in the same cycle, the
// compare stage works on the registered read data, and a result register
// drives o_valid and the peak coordinates. The input is held off only while
// the compare stage has a peak that the stalled result register cannot take.
// Writing either count register restarts the matrix; early flushes and
// surplus samples are taken and dropped. The line stores need no clearing
// after reset.
module grid_local_peak_finder #(
    parameter int MAX_COLS     = 1024,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [glpf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_opcode,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [glpf_pkg::COORD_W-1:0]    o_peak_row,
    output logic [glpf_pkg::COORD_W-1:0]    o_peak_col
);

    import glpf_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int DRW = $clog2(MAX_ROWS);
    localparam int AW  = $clog2(MAX_COLS);
    localparam int CW  = $clog2(MAX_COLS + 1);

    logic                           ready;
    logic                           acc;
    t_dec_ctl                       dec;
    logic [DRW-1:0]                 drow;
    logic [AW-1:0]                  dcol;
    logic signed [SAMPLE_WIDTH-1:0] down;
    logic                           we_upper;
    logic                           we_lower;
    logic [AW-1:0]                  waddr;
    logic [SAMPLE_WIDTH-1:0]        wdata;
    logic [AW-1:0]                  raddr_a;
    logic [AW-1:0]                  raddr_b;
    logic [SAMPLE_WIDTH-1:0]        upper_a;
    logic [SAMPLE_WIDTH-1:0]        upper_b;
    logic [SAMPLE_WIDTH-1:0]        lower_a;
    logic [SAMPLE_WIDTH-1:0]        lower_b;

    assign acc     = i_valid && ready;
    assign o_stall = !ready;

    glpf_ctrl #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .RW           (RW),
        .DRW          (DRW),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_acc          (acc),
        .i_opcode       (i_opcode),
        .i_sample_value (i_sample_value),
        .o_dec          (dec),
        .o_drow         (drow),
        .o_dcol         (dcol),
        .o_down         (down),
        .o_we_upper     (we_upper),
        .o_we_lower     (we_lower),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr_a      (raddr_a),
        .o_raddr_b      (raddr_b)
    );

    // even rows
    glpf_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (AW),
        .DW    (SAMPLE_WIDTH)
    ) u_upper (
        .i_clk     (i_clk),
        .i_we      (we_upper),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (dec.load),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (upper_a),
        .o_rdata_b (upper_b)
    );

    // odd rows
    glpf_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (AW),
        .DW    (SAMPLE_WIDTH)
    ) u_lower (
        .i_clk     (i_clk),
        .i_we      (we_lower),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (dec.load),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (lower_a),
        .o_rdata_b (lower_b)
    );

    glpf_decide #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DRW          (DRW),
        .AW           (AW)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dec      (dec),
        .i_drow     (drow),
        .i_dcol     (dcol),
        .i_down     (down),
        .i_upper_a  (upper_a),
        .i_upper_b  (upper_b),
        .i_lower_a  (lower_a),
        .i_lower_b  (lower_b),
        .i_stall    (i_stall),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .o_peak_row (o_peak_row),
        .o_peak_col (o_peak_col)
    );

endmodule

// ===== verif/glpf_peak_checker.sv =====
`timescale 1ns / 1ps

module glpf_peak_checker #(
    parameter int MAX_COLS     = 1024,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [glpf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_opcode,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [glpf_pkg::COORD_W-1:0]    i_peak_row,
    input  logic [glpf_pkg::COORD_W-1:0]    i_peak_col,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_items_in,
    output int                              o_peaks_seen
);

    import glpf_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_peak_pos;

    t_peak_pos expected_peaks[$];

    logic [CFG_W-1:0]               row_count_reg;
    logic [CFG_W-1:0]               col_count_reg;
    logic signed [SAMPLE_WIDTH-1:0] upper_line [MAX_COLS];
    logic signed [SAMPLE_WIDTH-1:0] lower_line [MAX_COLS];
    int unsigned                    next_row;
    int unsigned                    next_col;
    int unsigned                    judge_row;
    int unsigned                    judge_col;
    int                             fail_total = 0;
    int                             items_total = 0;
    int                             peaks_total = 0;

    assign o_fail_count = fail_total;
    assign o_items_in   = items_total;
    assign o_peaks_seen = peaks_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        if (fail_total <= 50) begin
            $display("%0t peak mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                               input int unsigned limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // even rows sit in the upper line, odd rows in the lower one
    function automatic logic signed [SAMPLE_WIDTH-1:0] line_at(input int unsigned row,
                                                               input int unsigned col);
        return (row % 2) ? lower_line[col] : upper_line[col];
    endfunction

    function automatic bit judge_is_peak(input int unsigned cols, input bit has_down,
                                         input logic signed [SAMPLE_WIDTH-1:0] down);
        logic signed [SAMPLE_WIDTH-1:0] v;
        bit ok;
        v  = line_at(judge_row, judge_col);
        ok = 1'b1;
        if (judge_row >= 1 && v < line_at(judge_row - 1, judge_col)) ok = 1'b0;
        if (judge_col >= 1 && v < line_at(judge_row, judge_col - 1)) ok = 1'b0;
        if (judge_col + 1 < cols && v < line_at(judge_row, judge_col + 1)) ok = 1'b0;
        if (has_down && v < down) ok = 1'b0;
        return ok;
    endfunction

    task automatic clear_positions();
        next_row  = 0;
        next_col  = 0;
        judge_row = 0;
        judge_col = 0;
    endtask

    task automatic advance_judge(input int unsigned cols);
        judge_col++;
        if (judge_col >= cols) begin
            judge_col = 0;
            judge_row++;
        end
    endtask

    task automatic track_item(input logic op, input logic signed [SAMPLE_WIDTH-1:0] value);
        int unsigned rows;
        int unsigned cols;
        bit          found;
        bit          decides;
        t_peak_pos   pos;
        rows    = clamp_size(row_count_reg, MAX_ROWS);
        cols    = clamp_size(col_count_reg, MAX_COLS);
        found   = 1'b0;
        pos.row = judge_row[COORD_W-1:0];
        pos.col = judge_col[COORD_W-1:0];
        if (op == OP_SAMPLE) begin
            // surplus sample once the matrix is complete
            if (next_row >= rows) return;
            decides = (next_row >= 1);
            if (decides) found = judge_is_peak(cols, 1'b1, value);
            if (next_row % 2) begin
                lower_line[next_col] = value;
            end else begin
                upper_line[next_col] = value;
            end
            next_col++;
            if (next_col >= cols) begin
                next_col = 0;
                next_row++;
            end
            if (decides) advance_judge(cols);
        end else begin
            // flush before the last sample is dropped
            if (next_row < rows) return;
            found = judge_is_peak(cols, 1'b0, '0);
            advance_judge(cols);
            if (judge_row >= rows) clear_positions();
        end
        if (found) expected_peaks.push_back(pos);
    endtask

    always @(posedge i_clk) begin
        t_peak_pos got;
        t_peak_pos want;
        if (!i_rst_n) begin
            row_count_reg = 1;
            col_count_reg = 1;
            clear_positions();
            expected_peaks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.row = i_peak_row;
                got.col = i_peak_col;
                peaks_total++;
                if (expected_peaks.size() == 0) begin
                    report_mismatch($sformatf("peak (%0d,%0d) with none expected",
                                              got.row, got.col));
                end else begin
                    want = expected_peaks.pop_front();
                    if (got.row != want.row) begin
                        report_mismatch($sformatf("row %0d, expected %0d (col %0d)",
                                                  got.row, want.row, want.col));
                    end
                    if (got.col != want.col) begin
                        report_mismatch($sformatf("col %0d, expected %0d (row %0d)",
                                                  got.col, want.col, want.row));
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROW_COUNT) begin
                    row_count_reg = i_cfg_data;
                end else begin
                    col_count_reg = i_cfg_data;
                end
                // any count write restarts the matrix
                clear_positions();
            end
            if (i_in_valid && !i_in_stall) begin
                items_total++;
                track_item(i_opcode, i_sample_value);
            end
        end
        o_pending <= expected_peaks.size();
    end

endmodule

// ===== verif/tb_grid_local_peak_finder.sv =====
`timescale 1ns / 1ps

module tb_grid_local_peak_finder;

    import glpf_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 900;

    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef enum {VALUES_FULL, VALUES_TIES, VALUES_EXTREME} t_value_mix;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_W-1:0]               i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_opcode;
    logic signed [SAMPLE_WIDTH-1:0] i_sample_value;
    logic                           o_valid;
    logic                           i_stall;
    logic [COORD_W-1:0]             o_peak_row;
    logic [COORD_W-1:0]             o_peak_col;

    int fail_count;
    int pending_peaks;
    int items_in;
    int peaks_seen;
    int idle_cycles;
    int matrix_total;
    int noise_total;
    int counted_items;
    bit hold_request;
    bit quiet_phase;

    grid_local_peak_finder #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_peak_row     (o_peak_row),
        .o_peak_col     (o_peak_col)
    );

    glpf_peak_checker #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_peak_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_opcode       (i_opcode),
        .i_sample_value (i_sample_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_peak_row     (o_peak_row),
        .i_peak_col     (o_peak_col),
        .o_fail_count   (fail_count),
        .o_pending      (pending_peaks),
        .o_items_in     (items_in),
        .o_peaks_seen   (peaks_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // no transfer of any kind for too long means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[grid_local_peak_finder] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall runs, plus one long hold-off on request
    initial begin : result_side
        int   r;
        int   len;
        logic level;
        i_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                level        = 1'b1;
                len          = LONG_HOLD;
                hold_request = 1'b0;
            end else if (quiet_phase) begin
                level = 1'b0;
                len   = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    level = 1'b0;
                    len   = $urandom_range(1, 8);
                end else if (r < 95) begin
                    level = 1'b1;
                    len   = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    len   = $urandom_range(10, 50);
                end
            end
            i_stall <= level;
            repeat (len) @(negedge i_clk);
        end
    end

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_value(input t_value_mix mix);
        logic signed [SAMPLE_WIDTH-1:0] v;
        v = SAMPLE_WIDTH'($urandom);
        if (mix == VALUES_TIES) begin
            v = SAMPLE_WIDTH'($urandom_range(0, 2));
            v = v - 1;
        end else if (mix == VALUES_EXTREME) begin
            case ($urandom_range(0, 3))
                0:       v = VAL_MIN;
                1:       v = VAL_MAX;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    // called at a falling edge; mostly no gap, some short gaps, a few long ones
    task automatic sender_gap();
        int r;
        int len;
        len = 0;
        if (!quiet_phase) begin
            r = $urandom_range(0, 99);
            if (r >= 93) begin
                len = $urandom_range(8, 40);
            end else if (r >= 65) begin
                len = $urandom_range(1, 3);
            end
        end
        if (len > 0) begin
            i_valid <= 1'b0;
            repeat (len) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input logic op, input logic signed [SAMPLE_WIDTH-1:0] value);
        sender_gap();
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // wait for every expected peak, then for the compare pipeline to empty
    task automatic settle_block();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_peaks != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_size(input logic [CFG_W-1:0] raw_rows,
                                input logic [CFG_W-1:0] raw_cols);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROW_COUNT;
        i_cfg_data <= raw_rows;
        @(negedge i_clk);
        i_cfg_idx  <= REG_COL_COUNT;
        i_cfg_data <= raw_cols;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_matrix(input logic [CFG_W-1:0] raw_rows,
                              input logic [CFG_W-1:0] raw_cols,
                              input t_value_mix mix, input bit noisy, input bit choke);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        int unsigned cut;
        int unsigned early_at;
        int unsigned extra;
        program_size(raw_rows, raw_cols);
        rows     = (raw_rows == 0) ? 1 : ((raw_rows > MAX_ROWS) ? MAX_ROWS : raw_rows);
        cols     = (raw_cols == 0) ? 1 : ((raw_cols > MAX_COLS) ? MAX_COLS : raw_cols);
        total    = rows * cols;
        cut      = total;
        early_at = total + 1;
        extra    = 0;
        if (noisy) begin
            noise_total++;
            case ($urandom_range(0, 3))
                0: early_at = $urandom_range(0, total - 1);
                1: extra = $urandom_range(1, 3);
                2: cut = $urandom_range(0, total - 1);
                default: begin
                    early_at = $urandom_range(0, total - 1);
                    extra    = $urandom_range(1, 3);
                end
            endcase
        end
        if (choke) begin
            quiet_phase  = 1'b1;
            hold_request = 1'b1;
        end
        for (int unsigned k = 0; k < cut; k++) begin
            if (k == early_at) send_item(OP_FLUSH, pick_value(VALUES_FULL));
            send_item(OP_SAMPLE, pick_value(mix));
            counted_items++;
        end
        // an abandoned matrix gets neither surplus samples nor flushes
        if (cut == total) begin
            repeat (extra) send_item(OP_SAMPLE, pick_value(mix));
            repeat (cols) begin
                send_item(OP_FLUSH, pick_value(VALUES_FULL));
                counted_items++;
            end
        end
        quiet_phase = 1'b0;
        matrix_total++;
    endtask

    initial begin : stimulus
        int          r;
        int unsigned rr;
        int unsigned cc;
        t_value_mix  mix;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_ROW_COUNT;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_opcode       = OP_SAMPLE;
        i_sample_value = '0;
        hold_request   = 1'b0;
        quiet_phase    = 1'b0;
        matrix_total   = 0;
        noise_total    = 0;
        counted_items  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 1x1 after reset: early flush, the sample, a surplus sample, the flush
        send_item(OP_FLUSH, 0);
        send_item(OP_SAMPLE, VAL_MAX);
        send_item(OP_SAMPLE, VAL_MIN);
        send_item(OP_FLUSH, VAL_MIN);
        // zero counts behave as one
        program_size(0, 0);
        send_item(OP_SAMPLE, VAL_MIN);
        send_item(OP_FLUSH, VAL_MAX);
        // single row, early flush in the middle
        program_size(1, 3);
        send_item(OP_SAMPLE, VAL_MIN);
        send_item(OP_SAMPLE, VAL_MAX);
        send_item(OP_FLUSH, 0);
        send_item(OP_SAMPLE, -1);
        repeat (3) send_item(OP_FLUSH, 0);
        // single column with equal neighbors
        program_size(3, 1);
        send_item(OP_SAMPLE, 5);
        send_item(OP_SAMPLE, 5);
        send_item(OP_SAMPLE, -2);
        send_item(OP_FLUSH, 0);
        // count write abandons a half-sent matrix
        program_size(2, 2);
        send_item(OP_SAMPLE, 7);
        send_item(OP_SAMPLE, 9);
        program_size(2, 2);
        repeat (4) send_item(OP_SAMPLE, 0);
        repeat (2) send_item(OP_FLUSH, 0);

        // values from -1 to 1 give many ties while the result side holds off
        run_matrix(8, 8, VALUES_TIES, 1'b0, 1'b1);
        // oversize row count saturates to the tallest single column
        run_matrix('1, 1, VALUES_FULL, 1'b0, 1'b0);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                rr = $urandom_range(1, 6);
                cc = $urandom_range(1, 8);
            end else begin
                rr = $urandom_range(1, 24);
                cc = $urandom_range(1, 40);
            end
            if ($urandom_range(0, 19) == 0) rr = 0;
            if ($urandom_range(0, 19) == 0) cc = 0;
            r = $urandom_range(0, 99);
            mix = (r < 50) ? VALUES_FULL : ((r < 85) ? VALUES_TIES : VALUES_EXTREME);
            quiet_phase = ($urandom_range(0, 4) == 0);
            run_matrix(CFG_W'(rr), CFG_W'(cc), mix, $urandom_range(0, 99) < 15, 1'b0);
        end

        settle_block();
        $display("covered %0d matrices (%0d with dropped or abandoned items), up to %0d rows",
                 matrix_total, noise_total, MAX_ROWS);
        $display("%0d input transfers, %0d peaks compared, %0d mismatches",
                 items_in, peaks_seen, fail_count);
        if (fail_count == 0) begin
            $display("[grid_local_peak_finder] OK");
        end else begin
            $display("[grid_local_peak_finder] ERROR");
        end
        $finish;
    end

endmodule
